@@ src/jst3d_pkg.sv @@
package jst3d_pkg;

	// payload field widths, fixed by the stream format
	localparam int SAMPLE_W = 16;
	localparam int GRID_W   = 7;

	// defaults for the top-level parameters
	localparam int DEFAULT_MAX_DIM     = 64;
	localparam int DEFAULT_SAMPLE_BITS = 16;

	// APB register map
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;
	localparam int REG_IDX_W  = 1;
	localparam logic [REG_IDX_W-1:0] REG_GRID_SIZE = 1'b0;

	localparam logic [GRID_W-1:0] GRID_RESET = 7'd4;
	localparam int GRID_MIN = 3;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                drain;
	} in_beat_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] value;
		logic                last;
	} out_beat_t;

endpackage

@@ src/jacobi_stencil_3d_7pt.sv @@
// Seven-point 3D Jacobi stencil, one sweep per pass over an N x N x N grid
// (N from register grid_size, clamped to 3..MAX_DIM, reset 4). Voxels enter
// in plane, row, column order, one beat per cycle when not stalled; after the
// grid the host sends N*N drain beats. The first N*N beats of a sweep only
// fill the window; each later beat yields the voxel that entered N*N beats
// before it. Interior voxels become (sum of self and six face
// neighbours + 3) / 7, boundary voxels pass unchanged, and last marks the
// final voxel. Throughput is one beat per cycle while result_ready does not
// stall the output, set by the two delay-line RAMs that each take one write
// and one read per beat. Bubbles collapse, so input is taken while a result
// waits whenever a stage is free. Writing grid_size restarts the sweep; it
// may only be written with the block idle. No memory clearing pass is needed
// after reset: window entries are only read once written in the current sweep.
module jacobi_stencil_3d_7pt #(
	parameter int MAX_DIM     = jst3d_pkg::DEFAULT_MAX_DIM,
	parameter int SAMPLE_BITS = jst3d_pkg::DEFAULT_SAMPLE_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// voxel stream in
	input  logic                                voxel_valid,
	output logic                                voxel_ready,
	input  jst3d_pkg::in_beat_t                 voxel,
	// result stream out
	output logic                                result_valid,
	input  logic                                result_ready,
	output jst3d_pkg::out_beat_t                result,
	// APB config
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [jst3d_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [jst3d_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [jst3d_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                pready
);

	localparam int SW     = SAMPLE_BITS;
	localparam int DIM_W  = $clog2(MAX_DIM);             // voxel index 0..N-1
	localparam int N_W    = $clog2(MAX_DIM + 1);         // N itself
	localparam int SQ_W   = 2 * N_W;
	localparam int NN_W   = $clog2(MAX_DIM * MAX_DIM + 1);
	localparam int PL_DEPTH = MAX_DIM * (MAX_DIM - 1);   // plane delay, N*N-N-1 max
	localparam int PL_AW  = $clog2(PL_DEPTH);
	localparam int RW_DEPTH = MAX_DIM;                   // row delay, N-2 max
	localparam int RW_AW  = $clog2(RW_DEPTH);
	localparam int SUM_W  = SW + 3;                      // 7 samples + rounding
	localparam int M_W    = SUM_W + 1;
	localparam int H_W    = M_W / 2;                     // low half of reciprocal
	localparam int P_W    = SUM_W + M_W;
	localparam int SHIFT  = SUM_W + 3;
	// ceil(2^(SUM_W+3) / 7): exact floor division by 7 for any SUM_W-bit value
	localparam logic [M_W-1:0] RECIP = M_W'(((64'd1 << SHIFT) + 64'd6) / 64'd7);

	// reset geometry
	localparam int RST_G  = int'(jst3d_pkg::GRID_RESET);
	localparam int RST_N  = (RST_G < jst3d_pkg::GRID_MIN) ? jst3d_pkg::GRID_MIN :
	                        ((RST_G > MAX_DIM) ? MAX_DIM : RST_G);

	typedef struct packed {
		logic is_edge;
		logic last;
	} pos_flags_t;

	// ---------------------------------------------------------------- config
	logic [jst3d_pkg::GRID_W-1:0] grid_q;
	logic [DIM_W-1:0]             nm1_q;      // N-1
	logic [NN_W-1:0]              nn_q;       // N*N
	logic [PL_AW-1:0]             pl_last_q;  // plane delay length - 1
	logic [RW_AW-1:0]             rw_last_q;  // row delay length - 1

	logic                         cfg_wr;
	logic [jst3d_pkg::GRID_W-1:0] g_new;
	logic [N_W-1:0]               n_new;
	logic [SQ_W-1:0]              sq_new;
	logic [SQ_W-1:0]              pl_len_m1;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite &&
	                (paddr[jst3d_pkg::APB_ADDR_W-1:2] == jst3d_pkg::REG_GRID_SIZE);
	assign g_new  = pwdata[jst3d_pkg::GRID_W-1:0];

	always_comb begin
		if (32'(g_new) < 32'(jst3d_pkg::GRID_MIN)) begin
			n_new = N_W'(jst3d_pkg::GRID_MIN);
		end else if (32'(g_new) > 32'(MAX_DIM)) begin
			n_new = N_W'(MAX_DIM);
		end else begin
			n_new = N_W'(g_new);
		end
	end

	assign sq_new    = SQ_W'(n_new) * SQ_W'(n_new);
	assign pl_len_m1 = sq_new - SQ_W'(n_new) - SQ_W'(2);

	always_comb begin
		if (paddr[jst3d_pkg::APB_ADDR_W-1:2] == jst3d_pkg::REG_GRID_SIZE) begin
			prdata = jst3d_pkg::APB_DATA_W'(grid_q);
		end else begin
			prdata = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_q    <= jst3d_pkg::GRID_RESET;
			nm1_q     <= DIM_W'(RST_N - 1);
			nn_q      <= NN_W'(RST_N * RST_N);
			pl_last_q <= PL_AW'(RST_N * RST_N - RST_N - 2);
			rw_last_q <= RW_AW'(RST_N - 3);
		end else if (cfg_wr) begin
			grid_q    <= g_new;
			nm1_q     <= DIM_W'(n_new - N_W'(1));
			nn_q      <= NN_W'(sq_new);
			pl_last_q <= PL_AW'(pl_len_m1);
			rw_last_q <= RW_AW'(n_new - N_W'(3));
		end
	end

	// ------------------------------------------------------ stage enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en2, en3, en4, en5;
	logic acc;

	assign en5          = !v_s5 || result_ready;
	assign en4          = !v_s4 || en5;
	assign en3          = !v_s3 || en4;
	assign en2          = !v_s2 || en3;
	assign voxel_ready  = !v_s1 || en2;
	assign acc          = voxel_valid && voxel_ready;

	// ------------------------------------------------------ sweep position
	logic [NN_W-1:0]  fill_q;
	logic [DIM_W-1:0] plane_q, row_q, col_q;
	logic             filling;
	pos_flags_t       cur_flags;

	assign filling = (fill_q != nn_q);

	always_comb begin
		cur_flags.is_edge = (plane_q == '0) || (plane_q == nm1_q) ||
		                    (row_q == '0)   || (row_q == nm1_q)   ||
		                    (col_q == '0)   || (col_q == nm1_q);
		cur_flags.last    = (plane_q == nm1_q) && (row_q == nm1_q) && (col_q == nm1_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			plane_q <= '0;
			row_q   <= '0;
			col_q   <= '0;
		end else if (cfg_wr) begin
			fill_q  <= '0;
			plane_q <= '0;
			row_q   <= '0;
			col_q   <= '0;
		end else if (acc) begin
			if (filling) begin
				fill_q <= fill_q + NN_W'(1);
			end else if (cur_flags.last) begin
				// end of sweep: next beat starts a new fill
				fill_q  <= '0;
				plane_q <= '0;
				row_q   <= '0;
				col_q   <= '0;
			end else if (col_q == nm1_q) begin
				col_q <= '0;
				if (row_q == nm1_q) begin
					row_q   <= '0;
					plane_q <= plane_q + DIM_W'(1);
				end else begin
					row_q <= row_q + DIM_W'(1);
				end
			end else begin
				col_q <= col_q + DIM_W'(1);
			end
		end
	end

	// ------------------------------------------------------ window
	// Delay chain with taps at back = 0, NN-N, NN-1, NN, NN+1, NN+N, 2NN.
	// Plane RAM holds two NN-N-1 delays side by side ({F, A}), row RAM two
	// N-2 delays ({E, B}); each RAM adds one more through its read register.
	logic [SW-1:0]      x_in;
	logic [SW-1:0]      x_s1;     // back 0   (plane + 1)
	logic [SW-1:0]      ta_s1;    // back NN-N (row + 1)
	logic [SW-1:0]      tb_s1;    // back NN-1 (col + 1)
	logic [SW-1:0]      tc_s1;    // back NN   (center)
	logic [SW-1:0]      td_s1;    // back NN+1 (col - 1)
	logic [SW-1:0]      te_s1;    // back NN+N (row - 1)
	logic [SW-1:0]      tf_s1;    // back 2NN  (plane - 1)
	logic [2*SW-1:0]    pl_rd_s1, rw_rd_s1;
	logic [PL_AW-1:0]   pl_ptr_q;
	logic [RW_AW-1:0]   rw_ptr_q;
	pos_flags_t         flags_s1;

	assign x_in  = voxel.drain ? '0 : SW'(voxel.sample);
	assign ta_s1 = pl_rd_s1[SW-1:0];
	assign tf_s1 = pl_rd_s1[2*SW-1:SW];
	assign tb_s1 = rw_rd_s1[SW-1:0];
	assign te_s1 = rw_rd_s1[2*SW-1:SW];

	// read-first: the slot read is the one being overwritten, written one delay ago
	jst3d_ram #(
		.WIDTH (2 * SW),
		.DEPTH (PL_DEPTH)
	) u_plane_ram (
		.clk   (clk),
		.we    (acc),
		.waddr (pl_ptr_q),
		.wdata ({te_s1, x_s1}),
		.re    (acc),
		.raddr (pl_ptr_q),
		.rdata (pl_rd_s1)
	);

	jst3d_ram #(
		.WIDTH (2 * SW),
		.DEPTH (RW_DEPTH)
	) u_row_ram (
		.clk   (clk),
		.we    (acc),
		.waddr (rw_ptr_q),
		.wdata ({td_s1, ta_s1}),
		.re    (acc),
		.raddr (rw_ptr_q),
		.rdata (rw_rd_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pl_ptr_q <= '0;
			rw_ptr_q <= '0;
		end else if (cfg_wr) begin
			pl_ptr_q <= '0;
			rw_ptr_q <= '0;
		end else if (acc) begin
			pl_ptr_q <= (pl_ptr_q == pl_last_q) ? '0 : pl_ptr_q + PL_AW'(1);
			rw_ptr_q <= (rw_ptr_q == rw_last_q) ? '0 : rw_ptr_q + RW_AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			x_s1     <= x_in;
			tc_s1    <= tb_s1;
			td_s1    <= tc_s1;
			flags_s1 <= cur_flags;
		end
	end

	// ------------------------------------------------------ arithmetic
	logic [SW:0]        pa_s2, pb_s2, pc_s2, pd_s2;
	logic [SW-1:0]      ctr_s2, ctr_s3, ctr_s4;
	pos_flags_t         flags_s2, flags_s3, flags_s4;
	logic [SUM_W-1:0]   sum_s3;
	logic [SUM_W+H_W-1:0]       plo_s4;
	logic [SUM_W+M_W-H_W-1:0]   phi_s4;
	logic [P_W-1:0]     prod;
	logic [SW-1:0]      quot;
	logic [SW-1:0]      res_s5;
	logic               last_s5;

	assign prod = (P_W'(phi_s4) << H_W) + P_W'(plo_s4);
	assign quot = SW'(prod >> SHIFT);

	always_ff @(posedge clk) begin
		if (en2) begin
			pa_s2    <= (SW+1)'(tc_s1) + (SW+1)'(tb_s1);
			pb_s2    <= (SW+1)'(td_s1) + (SW+1)'(ta_s1);
			pc_s2    <= (SW+1)'(te_s1) + (SW+1)'(x_s1);
			pd_s2    <= (SW+1)'(tf_s1) + (SW+1)'(3);   // rounding term
			ctr_s2   <= tc_s1;
			flags_s2 <= flags_s1;
		end
		if (en3) begin
			sum_s3   <= SUM_W'(pa_s2) + SUM_W'(pb_s2) + SUM_W'(pc_s2) + SUM_W'(pd_s2);
			ctr_s3   <= ctr_s2;
			flags_s3 <= flags_s2;
		end
		if (en4) begin
			// reciprocal product split in two halves
			plo_s4   <= (SUM_W+H_W)'(sum_s3) * (SUM_W+H_W)'(RECIP[H_W-1:0]);
			phi_s4   <= (SUM_W+M_W-H_W)'(sum_s3) * (SUM_W+M_W-H_W)'(RECIP[M_W-1:H_W]);
			ctr_s4   <= ctr_s3;
			flags_s4 <= flags_s3;
		end
		if (en5) begin
			res_s5  <= flags_s4.is_edge ? ctr_s4 : quot;
			last_s5 <= flags_s4.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (acc) begin
				v_s1 <= !filling;
			end else if (en2) begin
				v_s1 <= 1'b0;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (en4) begin
				v_s4 <= v_s3;
			end
			if (en5) begin
				v_s5 <= v_s4;
			end
		end
	end

	assign result_valid = v_s5;
	assign result.value = jst3d_pkg::SAMPLE_W'(res_s5);
	assign result.last  = last_s5;

endmodule

@@ src/jst3d_ram.sv @@
// simple dual-port RAM, registered read, read-first on same-address collision
module jst3d_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

endmodule

@@ src/jst3d_checker.sv @@
module jst3d_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             voxel_valid,
	input logic                             voxel_ready,
	input jst3d_pkg::in_beat_t              voxel,
	input logic                             result_valid,
	input logic                             result_ready,
	input jst3d_pkg::out_beat_t             result,
	input logic                             psel,
	input logic                             penable,
	input logic                             pwrite,
	input logic [jst3d_pkg::APB_ADDR_W-1:0] paddr,
	input logic [jst3d_pkg::APB_DATA_W-1:0] pwdata,
	input logic [jst3d_pkg::APB_DATA_W-1:0] prdata,
	input logic                             pready
);

	// stalled input beat holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		voxel_valid && !voxel_ready |=> voxel_valid && $stable(voxel))
		else $error("input beat changed while stalled");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// with nothing waiting at the output, the pipeline has room for a beat
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> voxel_ready)
		else $error("input blocked with empty output");

	a_no_result_in_reset: assert property (@(posedge clk)
		!arst_n |-> !result_valid)
		else $error("result valid during reset");

	// grid_size reads back what was written
	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready &&
		(paddr[jst3d_pkg::APB_ADDR_W-1:2] == jst3d_pkg::REG_GRID_SIZE)
		|=> (paddr[jst3d_pkg::APB_ADDR_W-1:2] != jst3d_pkg::REG_GRID_SIZE) ||
		    (prdata[jst3d_pkg::GRID_W-1:0] == $past(pwdata[jst3d_pkg::GRID_W-1:0])))
		else $error("grid_size readback mismatch");

endmodule

bind jacobi_stencil_3d_7pt jst3d_checker u_jst3d_checker (.*);
